// ----- hdl/rsb_pkg.sv -----
// Shared types and constants for the reversible sequence buffer.
// Used by rsb_ctrl, rsb_dp and reversible_sequence_buffer; depends on nothing.
`default_nettype none

package rsb_pkg;

  localparam int unsigned CAPACITY_DEF = 64;

  // Field widths fixed by the word format
  localparam int unsigned OP_W       = 3;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned INDEX_W    = 6;
  localparam int unsigned S_TDATA_W  = 48;  // value, index, index_end, zero fill
  localparam int unsigned S_TUSER_W  = OP_W;
  localparam int unsigned M_TDATA_W  = VALUE_W;
  localparam int unsigned M_TUSER_W  = 2;   // list_empty, bad_index

  typedef enum logic [OP_W-1:0] {
    OP_APPEND  = 3'd0,
    OP_GET     = 3'd1,
    OP_SHOW    = 3'd2,
    OP_REVERSE = 3'd3,
    OP_CUT     = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    OUT_DATA,
    OUT_GET_BAD,
    OUT_CUT,
    OUT_EMPTY
  } out_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic     latch;
    logic     append;
    logic     reverse;
    logic     cut;
    logic     rd_en;
    logic     out_load;
    out_sel_e out_sel;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            len_zero;
    logic            get_bad;
    logic            cut_bad;
    logic            show_done;
    logic            out_free;
  } status_t;

endpackage

`default_nettype wire

// ----- hdl/reversible_sequence_buffer.sv -----
// Top level of the reversible sequence buffer: an ordered list of signed words
// in a circular store, with append, get, show, reverse and cut.
// Append and reverse finish in the execute state; cut and a bad get load the
// output register from there, a good get first passes the store read register;
// show streams one word per cycle unless the output stalls; the store has one read port.
// Reset: asynchronous, active low; clears the list to empty, forward order.
`default_nettype none

module reversible_sequence_buffer #(
  parameter int unsigned CAPACITY = rsb_pkg::CAPACITY_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Command words
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [rsb_pkg::S_TDATA_W-1:0] s_axis_tdata,  // value[31:0], index[37:32],
                                                            // index_end[43:38], zero fill
  input  wire logic [rsb_pkg::S_TUSER_W-1:0] s_axis_tuser,  // op[2:0]
  // Result words
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [rsb_pkg::M_TDATA_W-1:0]      m_axis_tdata,  // item_value[31:0]
  output logic                               m_axis_tlast,  // is_last
  output logic [rsb_pkg::M_TUSER_W-1:0]      m_axis_tuser   // list_empty[0], bad_index[1]
);

  // The controller sequences each command word; the datapath owns the list
  // descriptor (front, length, direction), the store and the output register.
  // A result word waits in the output register while the next command is taken.
  rsb_pkg::cmd_t    cmd;
  rsb_pkg::status_t st;

  rsb_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .st_i          (st),
    .cmd_o         (cmd)
  );

  rsb_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cmd_i         (cmd),
    .st_o          (st)
  );

endmodule

`default_nettype wire

// ----- hdl/rsb_ctrl.sv -----
// Controller state machine of the reversible sequence buffer.
// Depends on rsb_pkg; drives rsb_dp through cmd_t and reads status_t.
`default_nettype none

module rsb_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire rsb_pkg::status_t st_i,
  output rsb_pkg::cmd_t         cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.out_sel = rsb_pkg::OUT_DATA;
    s_axis_tready = (state_q == S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end

      S_EXEC: begin
        unique case (st_i.op)
          rsb_pkg::OP_APPEND: begin
            cmd_o.append = 1'b1;
            state_d      = S_IDLE;
          end
          rsb_pkg::OP_REVERSE: begin
            cmd_o.reverse = 1'b1;
            state_d       = S_IDLE;
          end
          rsb_pkg::OP_GET: begin
            if (st_i.get_bad) begin
              if (st_i.out_free) begin
                cmd_o.out_load = 1'b1;
                cmd_o.out_sel  = rsb_pkg::OUT_GET_BAD;
                state_d        = S_IDLE;
              end
            end else begin
              cmd_o.rd_en = 1'b1;
              state_d     = S_READ;
            end
          end
          rsb_pkg::OP_SHOW: begin
            if (st_i.len_zero) begin
              if (st_i.out_free) begin
                cmd_o.out_load = 1'b1;
                cmd_o.out_sel  = rsb_pkg::OUT_EMPTY;
                state_d        = S_IDLE;
              end
            end else begin
              cmd_o.rd_en = 1'b1;
              state_d     = S_READ;
            end
          end
          rsb_pkg::OP_CUT: begin
            if (st_i.out_free) begin
              cmd_o.out_load = 1'b1;
              cmd_o.out_sel  = rsb_pkg::OUT_CUT;
              cmd_o.cut      = !st_i.cut_bad;
              state_d        = S_IDLE;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_READ: begin
        // read data is registered; hand it over once the output slot frees up
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = rsb_pkg::OUT_DATA;
          if (st_i.op == rsb_pkg::OP_SHOW && !st_i.show_done) begin
            cmd_o.rd_en = 1'b1;
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/rsb_dp.sv -----
// Datapath of the reversible sequence buffer: list pointers, circular store,
// address unit and output register. Depends on rsb_pkg; controlled by rsb_ctrl.
`default_nettype none

module rsb_dp #(
  parameter int unsigned CAPACITY = rsb_pkg::CAPACITY_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic [rsb_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  input  wire logic [rsb_pkg::S_TUSER_W-1:0]   s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [rsb_pkg::M_TDATA_W-1:0]        m_axis_tdata,
  output logic                                 m_axis_tlast,
  output logic [rsb_pkg::M_TUSER_W-1:0]        m_axis_tuser,
  input  wire rsb_pkg::cmd_t                   cmd_i,
  output rsb_pkg::status_t                     st_o
);

  localparam int unsigned PW = $clog2(CAPACITY);
  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = (PW > rsb_pkg::INDEX_W) ? PW : rsb_pkg::INDEX_W;
  localparam int unsigned CW = (LW > rsb_pkg::INDEX_W) ? LW : rsb_pkg::INDEX_W;
  localparam int unsigned VW = rsb_pkg::VALUE_W;
  localparam int unsigned IW = rsb_pkg::INDEX_W;

  // Latched input word
  logic [rsb_pkg::OP_W-1:0] op_q;
  logic [VW-1:0]            value_q;
  logic [IW-1:0]            idx_q;
  logic [IW-1:0]            idx_end_q;

  // List descriptor
  logic [PW-1:0] front_q, front_d;
  logic [LW-1:0] len_q, len_d;
  logic          rev_q, rev_d;
  logic [LW-1:0] cnt_q, cnt_d;

  // Store and its read register
  logic [VW-1:0] mem [CAPACITY];
  logic [VW-1:0] rd_data_q;

  // Output register
  logic                          m_valid_q, m_valid_d;
  logic [VW-1:0]                 m_data_q;
  logic                          m_last_q;
  logic [rsb_pkg::M_TUSER_W-1:0] m_user_q;

  logic [AW-1:0] idx_ext;
  logic [PW-1:0] idx_k;
  logic [LW-1:0] len_m1;
  logic [PW-1:0] k_sel;
  logic [PW:0]   cap_x;
  logic [PW:0]   sum;
  logic [PW-1:0] phys;
  logic [CW-1:0] a_c, b_c, len_c, cut_len;
  logic          full;
  logic          out_free;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q      <= s_axis_tuser;
      value_q   <= s_axis_tdata[VW-1:0];
      idx_q     <= s_axis_tdata[VW+IW-1:VW];
      idx_end_q <= s_axis_tdata[VW+2*IW-1:VW+IW];
    end
  end

  assign idx_ext = AW'(idx_q);
  assign idx_k   = idx_ext[PW-1:0];
  assign len_m1  = len_q - LW'(1);
  assign a_c     = CW'(idx_q);
  assign b_c     = CW'(idx_end_q);
  assign len_c   = CW'(len_q);
  assign full    = (len_q == LW'(CAPACITY));

  // One shared address unit: logical position to store entry
  always_comb begin
    case (op_q)
      rsb_pkg::OP_APPEND:  k_sel = len_q[PW-1:0];
      rsb_pkg::OP_REVERSE: k_sel = len_m1[PW-1:0];
      rsb_pkg::OP_SHOW:    k_sel = cnt_q[PW-1:0];
      default:             k_sel = idx_k;
    endcase
  end

  always_comb begin
    cap_x = (PW+1)'(CAPACITY);
    if (rev_q) begin
      sum = {1'b0, front_q} - {1'b0, k_sel};
      if (sum[PW]) begin
        sum = sum + cap_x;
      end
    end else begin
      sum = {1'b0, front_q} + {1'b0, k_sel};
      if (sum >= cap_x) begin
        sum = sum - cap_x;
      end
    end
    phys = sum[PW-1:0];
  end

  assign cut_len = (a_c <= b_c) ? (b_c - a_c + CW'(1)) : (len_c - a_c);

  always_comb begin
    front_d = front_q;
    len_d   = len_q;
    rev_d   = rev_q;
    cnt_d   = cnt_q;
    if (cmd_i.latch) begin
      cnt_d = '0;
    end
    if (cmd_i.rd_en) begin
      cnt_d = cnt_q + LW'(1);
    end
    if (cmd_i.append && !full) begin
      len_d = len_q + LW'(1);
    end
    if (cmd_i.reverse) begin
      rev_d = ~rev_q;
      if (len_q != '0) begin
        front_d = phys;
      end
    end
    if (cmd_i.cut) begin
      front_d = phys;
      len_d   = cut_len[LW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q   <= '0;
      len_q     <= '0;
      rev_q     <= 1'b0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      front_q   <= front_d;
      len_q     <= len_d;
      rev_q     <= rev_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append && !full) begin
      mem[phys] <= value_q;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[phys];
    end
  end

  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    m_valid_d = m_valid_q;
    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (cmd_i.out_load) begin
      m_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      case (cmd_i.out_sel)
        rsb_pkg::OUT_DATA: begin
          m_data_q <= rd_data_q;
          m_last_q <= (op_q == rsb_pkg::OP_GET) || (cnt_q == len_q);
          m_user_q <= 2'b00;
        end
        rsb_pkg::OUT_GET_BAD: begin
          m_data_q <= '0;
          m_last_q <= 1'b1;
          m_user_q <= 2'b10;
        end
        rsb_pkg::OUT_EMPTY: begin
          m_data_q <= '0;
          m_last_q <= 1'b1;
          m_user_q <= 2'b01;
        end
        default: begin
          m_data_q <= '0;
          m_last_q <= 1'b0;
          m_user_q <= {st_o.cut_bad, 1'b0};
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_user_q;

  assign st_o.op        = op_q;
  assign st_o.len_zero  = (len_q == '0);
  assign st_o.get_bad   = (a_c >= len_c);
  assign st_o.cut_bad   = (a_c >= len_c) || (b_c >= len_c);
  assign st_o.show_done = (cnt_q == len_q);
  assign st_o.out_free  = out_free;

endmodule

`default_nettype wire

// ----- dv/rsb_result_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the reversible sequence buffer: mirrors the list state,
// predicts every result word from the accepted command words and compares them.
// Depends on rsb_pkg for field widths and op codes.
module rsb_result_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [rsb_pkg::S_TDATA_W-1:0] s_axis_tdata,   // value, index, index_end, zero fill
  input  logic [rsb_pkg::S_TUSER_W-1:0] s_axis_tuser,   // op
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [rsb_pkg::M_TDATA_W-1:0] m_axis_tdata,   // item_value
  input  logic                          m_axis_tlast,   // is_last
  input  logic [rsb_pkg::M_TUSER_W-1:0] m_axis_tuser,   // list_empty, bad_index
  output int unsigned                   mismatch_count_o,
  output int unsigned                   pending_words_o
);

  localparam int unsigned DEPTH        = rsb_pkg::CAPACITY_DEF;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned VW           = rsb_pkg::VALUE_W;
  localparam int unsigned IW           = rsb_pkg::INDEX_W;

  typedef struct packed {
    logic [VW-1:0] item_value;
    logic          is_last;
    logic          list_empty;
    logic          bad_index;
  } result_word_t;

  // Mirror of the list: circular store, front slot, length, direction
  logic [VW-1:0]      list_mem [DEPTH];
  int unsigned        front_slot = 0;
  int unsigned        list_len   = 0;
  logic               backward   = 1'b0;
  result_word_t       expected_words [$];
  int unsigned        mismatches = 0;

  // Physical slot of logical position pos
  function automatic int unsigned slot_of(int unsigned pos);
    if (backward) return (front_slot + DEPTH - pos % DEPTH) % DEPTH;
    return (front_slot + pos) % DEPTH;
  endfunction

  task automatic push_word(logic [VW-1:0] v, logic lst, logic emp, logic bad);
    result_word_t w;
    w = '{item_value: v, is_last: lst, list_empty: emp, bad_index: bad};
    expected_words.push_back(w);
  endtask

  task automatic predict_command(logic [rsb_pkg::OP_W-1:0] op, logic [VW-1:0] value,
                                 int unsigned idx_first, int unsigned idx_last);
    int unsigned new_front;
    case (op)
      rsb_pkg::OP_APPEND: begin
        // drop the word when the list is full
        if (list_len < DEPTH) begin
          list_mem[slot_of(list_len)] = value;
          list_len++;
        end
      end
      rsb_pkg::OP_GET: begin
        if (idx_first >= list_len) push_word('0, 1'b1, 1'b0, 1'b1);
        else push_word(list_mem[slot_of(idx_first)], 1'b1, 1'b0, 1'b0);
      end
      rsb_pkg::OP_SHOW: begin
        if (list_len == 0) begin
          push_word('0, 1'b1, 1'b1, 1'b0);
        end else begin
          for (int unsigned i = 0; i < list_len; i++)
            push_word(list_mem[slot_of(i)], (i + 1 == list_len), 1'b0, 1'b0);
        end
      end
      rsb_pkg::OP_REVERSE: begin
        // last element becomes the front; no data moves
        if (list_len > 0) front_slot = slot_of(list_len - 1);
        backward = ~backward;
      end
      rsb_pkg::OP_CUT: begin
        if (idx_first >= list_len || idx_last >= list_len) begin
          push_word('0, 1'b0, 1'b0, 1'b1);
        end else begin
          new_front = slot_of(idx_first);
          // an inverted range keeps everything from idx_first to the old end
          list_len  = (idx_first <= idx_last) ? idx_last - idx_first + 1
                                              : list_len - idx_first;
          front_slot = new_front;
          push_word('0, 1'b0, 1'b0, 1'b0);
        end
      end
      default: ;  // spare op codes change nothing
    endcase
  endtask

  task automatic compare_word();
    result_word_t got;
    result_word_t want;
    got = '{item_value: m_axis_tdata, is_last: m_axis_tlast,
            list_empty: m_axis_tuser[0], bad_index: m_axis_tuser[1]};
    if (expected_words.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("[%0t] unexpected result word: value %0d last %b empty %b bad %b",
                 $realtime, $signed(got.item_value), got.is_last, got.list_empty,
                 got.bad_index);
    end else begin
      want = expected_words.pop_front();
      if (got.item_value !== want.item_value || got.is_last !== want.is_last ||
          got.list_empty !== want.list_empty || got.bad_index !== want.bad_index) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display({"[%0t] result mismatch: expected value %0d last %b empty %b bad %b,",
                    " got value %0d last %b empty %b bad %b"},
                   $realtime, $signed(want.item_value), want.is_last, want.list_empty,
                   want.bad_index, $signed(got.item_value), got.is_last, got.list_empty,
                   got.bad_index);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_slot = 0;
      list_len   = 0;
      backward   = 1'b0;
      expected_words.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        predict_command(s_axis_tuser, s_axis_tdata[VW-1:0],
                        32'(s_axis_tdata[VW +: IW]),
                        32'(s_axis_tdata[VW+IW +: IW]));
      if (m_axis_tvalid && m_axis_tready) compare_word();
    end
    mismatch_count_o = mismatches;
    pending_words_o  = $unsigned(expected_words.size());
  end

endmodule

// ----- dv/tb_reversible_sequence_buffer.sv -----
`timescale 1ns / 1ps
// Testbench top for the reversible sequence buffer: clock, reset, command
// stimulus with bursty sending and a stalling result sink, and the verdict.
// Depends on rsb_pkg, the block itself and rsb_result_checker.
module tb_reversible_sequence_buffer;

  typedef logic [rsb_pkg::OP_W-1:0]    op_t;
  typedef logic [rsb_pkg::VALUE_W-1:0] value_t;
  typedef logic [rsb_pkg::INDEX_W-1:0] index_t;

  localparam int unsigned CMD_TARGET   = 460;
  localparam int unsigned FULL         = rsb_pkg::CAPACITY_DEF;
  localparam int unsigned MAX_INDEX    = (1 << rsb_pkg::INDEX_W) - 1;
  localparam int unsigned LIMIT_CYCLES = 500000;
  localparam int unsigned TAIL_CYCLES  = 24;
  localparam int unsigned FILL_W       = rsb_pkg::S_TDATA_W - rsb_pkg::VALUE_W
                                         - 2 * rsb_pkg::INDEX_W;
  localparam op_t OP_SPARE_LO = 3'd5;
  localparam op_t OP_SPARE_HI = 3'd7;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_MOSTLY,
    READY_RARELY,
    READY_PERIODIC
  } stall_mode_e;

  typedef enum logic [2:0] {
    SEQ_GROW,
    SEQ_FILL,
    SEQ_GET,
    SEQ_SHOW,
    SEQ_CUT,
    SEQ_REVERSE,
    SEQ_BROKEN,
    SEQ_NOISE
  } seq_kind_e;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [rsb_pkg::S_TDATA_W-1:0]  s_axis_tdata  = '0;  // value[31:0], index[37:32],
                                                       // index_end[43:38]
  logic [rsb_pkg::S_TUSER_W-1:0]  s_axis_tuser  = '0;  // op[2:0]
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [rsb_pkg::M_TDATA_W-1:0]  m_axis_tdata;        // item_value[31:0]
  logic                           m_axis_tlast;        // is_last
  logic [rsb_pkg::M_TUSER_W-1:0]  m_axis_tuser;        // list_empty[0], bad_index[1]

  int unsigned mismatch_count;
  int unsigned pending_words;
  int unsigned cycle_count   = 0;
  int unsigned results_seen  = 0;
  int unsigned words_sent    = 0;
  int unsigned counted_cmds  = 0;
  int unsigned fills_done    = 0;
  int unsigned tracked_len   = 0;   // list length, only to steer the indices
  int unsigned burst_left    = 0;
  stall_mode_e stall_mode    = READY_ALWAYS;
  int unsigned mode_left     = 0;
  int unsigned stall_phase   = 0;

  reversible_sequence_buffer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  rsb_result_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tlast     (m_axis_tlast),
    .m_axis_tuser     (m_axis_tuser),
    .mismatch_count_o (mismatch_count),
    .pending_words_o  (pending_words)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (m_axis_tvalid && m_axis_tready) results_seen++;
  end

  // Result sink: switch to a randomly chosen stall mode whenever the current one runs out
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      mode_left  = $urandom_range(20, 150);
    end else begin
      mode_left--;
    end
    stall_phase++;
    case (stall_mode)
      READY_ALWAYS:   m_axis_tready <= 1'b1;
      READY_MOSTLY:   m_axis_tready <= ($urandom_range(0, 3) != 0);
      READY_RARELY:   m_axis_tready <= ($urandom_range(0, 3) == 0);
      READY_PERIODIC: m_axis_tready <= (stall_phase % 5 == 0);
      default:        m_axis_tready <= 1'b1;
    endcase
  end

  // Track the list length and count commands that the block acts on
  function automatic void track_command(op_t op, int unsigned idx_first,
                                        int unsigned idx_last);
    case (op)
      rsb_pkg::OP_APPEND: begin
        if (tracked_len < FULL) begin
          tracked_len++;
          counted_cmds++;
        end
      end
      rsb_pkg::OP_GET, rsb_pkg::OP_SHOW, rsb_pkg::OP_REVERSE: counted_cmds++;
      rsb_pkg::OP_CUT: begin
        counted_cmds++;
        if (idx_first < tracked_len && idx_last < tracked_len)
          tracked_len = (idx_first <= idx_last) ? idx_last - idx_first + 1
                                                : tracked_len - idx_first;
      end
      default: ;
    endcase
  endfunction

  // Send one command word; the sender runs in bursts separated by gaps
  task automatic send_word(op_t op, value_t value, index_t idx_first, index_t idx_last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 25) : $urandom_range(1, 4);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{FILL_W{1'b0}}, idx_last, idx_first, value};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    track_command(op, 32'(idx_first), 32'(idx_last));
  endtask

  function automatic value_t rand_value();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Index inside the current list, or anywhere in the field
  function automatic index_t pick_index(bit in_list);
    if (in_list && tracked_len > 0) return index_t'($urandom_range(0, tracked_len - 1));
    return index_t'($urandom_range(0, MAX_INDEX));
  endfunction

  task automatic send_directed();
    // empty list: show, bad get, bad cut, reverse with nothing to move
    send_word(rsb_pkg::OP_SHOW,    rand_value(), 6'd0, 6'd0);
    send_word(rsb_pkg::OP_GET,     rand_value(), 6'd0, 6'd63);
    send_word(rsb_pkg::OP_CUT,     rand_value(), 6'd0, 6'd0);
    send_word(rsb_pkg::OP_REVERSE, rand_value(), 6'd63, 6'd63);
    // extremes of the value range, appended in reversed direction
    send_word(rsb_pkg::OP_APPEND,  32'h8000_0000, 6'd63, 6'd0);
    send_word(rsb_pkg::OP_APPEND,  32'h7fff_ffff, 6'd0, 6'd63);
    send_word(rsb_pkg::OP_APPEND,  32'h0000_0000, 6'd0, 6'd0);
    send_word(rsb_pkg::OP_APPEND,  32'hffff_ffff, 6'd63, 6'd63);
    send_word(rsb_pkg::OP_APPEND,  32'h0000_0005, 6'd21, 6'd42);
    send_word(rsb_pkg::OP_SHOW,    rand_value(), 6'd0, 6'd0);
    send_word(rsb_pkg::OP_GET,     rand_value(), 6'd0, 6'd0);
    send_word(rsb_pkg::OP_GET,     rand_value(), 6'd4, 6'd0);
    send_word(rsb_pkg::OP_GET,     rand_value(), 6'd5, 6'd0);
    send_word(rsb_pkg::OP_GET,     rand_value(), 6'd63, 6'd63);
    send_word(rsb_pkg::OP_REVERSE, rand_value(), 6'd0, 6'd0);
    send_word(rsb_pkg::OP_SHOW,    rand_value(), 6'd0, 6'd0);
    // narrowing cut, inverted cut, then cuts with one index past the end
    send_word(rsb_pkg::OP_CUT,     rand_value(), 6'd1, 6'd3);
    send_word(rsb_pkg::OP_CUT,     rand_value(), 6'd2, 6'd0);
    send_word(rsb_pkg::OP_CUT,     rand_value(), 6'd0, 6'd1);
    send_word(rsb_pkg::OP_CUT,     rand_value(), 6'd1, 6'd0);
    send_word(OP_SPARE_LO,         rand_value(), 6'd0, 6'd0);
    send_word(OP_SPARE_HI,         rand_value(), 6'd63, 6'd63);
    send_word(rsb_pkg::OP_SHOW,    rand_value(), 6'd0, 6'd0);
  endtask

  task automatic send_fill();
    int unsigned extra;
    extra = $urandom_range(1, 3);
    while (tracked_len < FULL)
      send_word(rsb_pkg::OP_APPEND, rand_value(), pick_index(1'b0), pick_index(1'b0));
    // appends to a full list are dropped
    repeat (extra)
      send_word(rsb_pkg::OP_APPEND, rand_value(), pick_index(1'b0), pick_index(1'b0));
    send_word(rsb_pkg::OP_SHOW,    rand_value(), pick_index(1'b0), pick_index(1'b0));
    send_word(rsb_pkg::OP_GET,     rand_value(), 6'd63, pick_index(1'b0));
    send_word(rsb_pkg::OP_REVERSE, rand_value(), pick_index(1'b0), pick_index(1'b0));
    send_word(rsb_pkg::OP_GET,     rand_value(), 6'd0, pick_index(1'b0));
    send_word(rsb_pkg::OP_SHOW,    rand_value(), pick_index(1'b0), pick_index(1'b0));
    fills_done++;
  endtask

  task automatic send_random();
    seq_kind_e   kind;
    int unsigned roll;
    while (counted_cmds < CMD_TARGET) begin
      roll = $urandom_range(0, 99);
      if (fills_done == 0 || roll < 2) kind = SEQ_FILL;
      else if (roll < 32)              kind = SEQ_GROW;
      else if (roll < 52)              kind = SEQ_GET;
      else if (roll < 60)              kind = SEQ_SHOW;
      else if (roll < 72)              kind = SEQ_CUT;
      else if (roll < 80)              kind = SEQ_REVERSE;
      else if (roll < 90)              kind = SEQ_BROKEN;
      else                             kind = SEQ_NOISE;
      case (kind)
        SEQ_FILL: send_fill();
        SEQ_GROW:
          repeat ($urandom_range(1, 6))
            send_word(rsb_pkg::OP_APPEND, rand_value(), pick_index(1'b0), pick_index(1'b0));
        SEQ_GET:
          send_word(rsb_pkg::OP_GET, rand_value(), pick_index(1'b1), pick_index(1'b0));
        SEQ_SHOW:
          send_word(rsb_pkg::OP_SHOW, rand_value(), pick_index(1'b0), pick_index(1'b0));
        SEQ_CUT:
          send_word(rsb_pkg::OP_CUT, rand_value(), pick_index(1'b1), pick_index(1'b1));
        SEQ_REVERSE:
          send_word(rsb_pkg::OP_REVERSE, rand_value(), pick_index(1'b0), pick_index(1'b0));
        SEQ_BROKEN: begin
          // indices anywhere in the field, the first cut index sometimes inside the list
          if ($urandom_range(0, 1))
            send_word(rsb_pkg::OP_GET, rand_value(), pick_index(1'b0), pick_index(1'b0));
          else
            send_word(rsb_pkg::OP_CUT, rand_value(), pick_index(1'($urandom_range(0, 1))),
                      pick_index(1'b0));
        end
        default:
          send_word(op_t'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), rand_value(),
                    pick_index(1'b0), pick_index(1'b0));
      endcase
    end
  endtask

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("Timeout after %0d cycles, %0d result words still expected",
             cycle_count, pending_words);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_directed();
    send_random();

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_words != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d command words (%0d acted on, %0d runs to a full list)",
             words_sent, counted_cmds, fills_done);
    $display("Checked %0d result words in %0d cycles", results_seen, cycle_count);
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- reversible_sequence_buffer.f -----
hdl/rsb_pkg.sv
hdl/rsb_ctrl.sv
hdl/rsb_dp.sv
hdl/reversible_sequence_buffer.sv
dv/rsb_result_checker.sv
dv/tb_reversible_sequence_buffer.sv
